/* hw/rtl/sacl_pkg.sv */
// Package for the set-associative LRU cache model: shared widths, register
// indexes, access type codes and reset values.
// No dependencies; used by the top level set_assoc_lru_cache_sim_unit.
package sacl_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 4;
  localparam int AGE_BITS_DEF     = 16;

  // Fixed field widths.
  localparam int ADDR_W     = 64;
  localparam int TOT_W      = 32;
  localparam int TYPE_W     = 2;
  localparam int HITS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SET_CFG_W  = 3;
  localparam int WAYS_CFG_W = 3;
  localparam int BLK_CFG_W  = 6;
  localparam int OUT_BITS   = HITS_W + 2 + 3 * TOT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  typedef logic [TYPE_W-1:0]    req_type_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Access types.
  localparam req_type_t REQ_IFETCH = 2'd0;
  localparam req_type_t REQ_LOAD   = 2'd1;
  localparam req_type_t REQ_STORE  = 2'd2;
  localparam req_type_t REQ_MODIFY = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_SET_BITS   = 2'd0;
  localparam cfg_idx_t CFG_WAYS       = 2'd1;
  localparam cfg_idx_t CFG_BLOCK_BITS = 2'd2;

  // Configuration reset values.
  localparam logic [SET_CFG_W-1:0]  SET_BITS_RST = 3'd4;
  localparam logic [WAYS_CFG_W-1:0] WAYS_RST     = 3'd1;
  localparam logic [BLK_CFG_W-1:0]  BLK_BITS_RST = 6'd4;

endpackage

/* hw/rtl/set_assoc_lru_cache_sim_unit.sv */
// Set-associative LRU cache model: tag/age RAM, per-line valid flops and a
// sequencer that walks the ways of one set with a single compare/age unit.
// Depends on sacl_pkg and sacl_ram.
//
//   channel | direction | contents
//   in_     | slave     | tdata: address[63:0]; tuser: req_type[1:0]
//   out_    | master    | tdata: hits_added, was_miss, was_eviction, totals
//   cfg_    | write     | cfg_addr selects the register, cfg_wdata its value
//
// An instruction fetch is taken and gives no result. Other accesses pass
// the address split, one read and one compare/age step per way through the
// single RAM port, then the result step with the fill or eviction write on
// a miss. Reset is synchronous; valid bits clear at once, so there is no
// clearing pass. The result register lets a new access be taken while a
// result waits; the final step of the next access waits for that register.
module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int AGE_BITS     = sacl_pkg::AGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]         in_tdata,   // address
  input  logic [sacl_pkg::TYPE_W-1:0]         in_tuser,   // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hits_added[1:0], was_miss, was_eviction, total_hits[31:0],
  // total_misses[31:0], total_evictions[31:0], zero padding
  output logic [sacl_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int ADDR_W    = sacl_pkg::ADDR_W;
  localparam int TOT_W     = sacl_pkg::TOT_W;
  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int NUM_LINES = NUM_SETS * MAX_WAYS;
  localparam int LINE_W    = $clog2(NUM_LINES);
  localparam int SET_W     = MAX_SET_BITS;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W     = $clog2(MAX_WAYS + 1);
  localparam int SBW       = $clog2(MAX_SET_BITS + 1);
  localparam int SH_W      = $clog2(ADDR_W + MAX_SET_BITS);
  localparam int ADD_W     = $clog2(2 * MAX_WAYS + 1);
  localparam int RAM_W     = ADDR_W + AGE_BITS;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  // Configuration.
  logic [sacl_pkg::SET_CFG_W-1:0]  set_bits_r, set_bits_nxt;
  logic [sacl_pkg::WAYS_CFG_W-1:0] ways_cfg_r, ways_cfg_nxt;
  logic [sacl_pkg::BLK_CFG_W-1:0]  blk_bits_r, blk_bits_nxt;

  // Sequencer and per-access state.
  logic [2:0]                state_r, state_nxt;
  sacl_pkg::req_type_t       type_r, type_nxt;
  logic [ADDR_W-1:0]         addr_r, addr_nxt;
  logic [ADDR_W-1:0]         tag_r, tag_nxt;
  logic [SET_W-1:0]          set_r, set_nxt;
  logic [WAY_W-1:0]          way_r, way_nxt;
  logic                      found_r, found_nxt;
  logic [ADD_W-1:0]          added_r, added_nxt;
  logic [AGE_BITS-1:0]       best_r, best_nxt;
  logic [WAY_W-1:0]          victim_r, victim_nxt;
  logic [MAX_WAYS-1:0]       valid_r [NUM_SETS];
  logic [MAX_WAYS-1:0]       valid_nxt [NUM_SETS];

  // Totals and result register.
  logic [TOT_W-1:0]          hit_total_r, hit_total_nxt;
  logic [TOT_W-1:0]          miss_total_r, miss_total_nxt;
  logic [TOT_W-1:0]          evict_total_r, evict_total_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [sacl_pkg::HITS_W-1:0] out_hits_r, out_hits_nxt;
  logic                      out_miss_r, out_miss_nxt;
  logic                      out_evict_r, out_evict_nxt;

  // Datapath.
  logic [SBW-1:0]            sbits_eff;
  logic [CNT_W-1:0]          ways_eff;
  logic [SH_W-1:0]           tag_shift;
  logic [SET_W-1:0]          set_mask;
  logic [SET_W-1:0]          set_calc;
  logic [ADDR_W-1:0]         tag_calc;
  logic [MAX_WAYS-1:0]       set_valid;
  logic [CNT_W-1:0]          fill;
  logic                      set_has_room;
  logic [WAY_W-1:0]          upd_way;
  logic [WAY_W-1:0]          sel_way;
  logic [LINE_W-1:0]         line_idx;
  logic                      ram_we;
  logic [RAM_W-1:0]          ram_wdata;
  logic [RAM_W-1:0]          ram_rdata;
  logic [ADDR_W-1:0]         rd_tag;
  logic [AGE_BITS-1:0]       rd_age;
  logic                      line_v;
  logic                      way_hit;
  logic [AGE_BITS-1:0]       new_age;
  logic [AGE_BITS-1:0]       cmp_age;
  logic [ADD_W-1:0]          added_fin;
  logic [TOT_W:0]            hit_sum;
  logic                      out_free;
  logic                      is_modify;

  // Clamp the configuration to what the storage supports.
  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      sbits_eff = SBW'(MAX_SET_BITS);
    end else begin
      sbits_eff = SBW'(set_bits_r);
    end
    if (ways_cfg_r == '0) begin
      ways_eff = CNT_W'(1);
    end else if (int'(ways_cfg_r) > MAX_WAYS) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_cfg_r);
    end
  end

  // Address split; the tag keeps every address bit above the set index.
  assign tag_shift = SH_W'(blk_bits_r) + SH_W'(sbits_eff);
  assign set_mask  = SET_W'((32'd1 << sbits_eff) - 32'd1);
  assign set_calc  = SET_W'(addr_r >> blk_bits_r) & set_mask;
  assign tag_calc  = (int'(tag_shift) < ADDR_W) ? (addr_r >> tag_shift) : '0;

  // Ways of a set always fill from way 0 upward, so the valid bits of a set
  // form a prefix and their count is the fill count.
  assign set_valid = valid_r[set_r];
  always_comb begin
    fill = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      fill = fill + CNT_W'(set_valid[i]);
    end
  end

  assign set_has_room = (fill < ways_eff);
  assign upd_way      = set_has_room ? WAY_W'(fill) : victim_r;
  assign sel_way      = (state_r == ST_UPD) ? upd_way : way_r;
  assign line_idx     = LINE_W'(set_r) * LINE_W'(MAX_WAYS) + LINE_W'(sel_way);

  sacl_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NUM_LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_idx),
    .wdata (ram_wdata),
    .raddr (line_idx),
    .rdata (ram_rdata)
  );

  // Shared compare and age unit, one way per pass.
  assign rd_tag    = ram_rdata[ADDR_W-1:0];
  assign rd_age    = ram_rdata[ADDR_W +: AGE_BITS];
  assign line_v    = set_valid[way_r];
  assign way_hit   = line_v && (rd_tag == tag_r);
  assign is_modify = (type_r == sacl_pkg::REQ_MODIFY);

  always_comb begin
    if (way_hit) begin
      new_age = AGE_BITS'(1);
    end else if (line_v && (rd_age != AGE_MAX)) begin
      new_age = rd_age + AGE_BITS'(1);
    end else begin
      new_age = rd_age;
    end
  end

  // An invalid line counts as age zero in the victim search.
  assign cmp_age   = line_v ? new_age : '0;
  assign added_fin = added_r + ((is_modify && !found_r) ? ADD_W'(1) : ADD_W'(0));
  assign hit_sum   = (TOT_W + 1)'(hit_total_r) + (TOT_W + 1)'(added_fin);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    set_bits_nxt    = set_bits_r;
    ways_cfg_nxt    = ways_cfg_r;
    blk_bits_nxt    = blk_bits_r;
    state_nxt       = state_r;
    type_nxt        = type_r;
    addr_nxt        = addr_r;
    tag_nxt         = tag_r;
    set_nxt         = set_r;
    way_nxt         = way_r;
    found_nxt       = found_r;
    added_nxt       = added_r;
    best_nxt        = best_r;
    victim_nxt      = victim_r;
    valid_nxt       = valid_r;
    hit_total_nxt   = hit_total_r;
    miss_total_nxt  = miss_total_r;
    evict_total_nxt = evict_total_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_hits_nxt    = out_hits_r;
    out_miss_nxt    = out_miss_r;
    out_evict_nxt   = out_evict_r;
    ram_we          = 1'b0;
    ram_wdata       = {new_age, rd_tag};

    if (cfg_we) begin
      unique case (cfg_addr)
        sacl_pkg::CFG_SET_BITS:   set_bits_nxt = cfg_wdata[sacl_pkg::SET_CFG_W-1:0];
        sacl_pkg::CFG_WAYS:       ways_cfg_nxt = cfg_wdata[sacl_pkg::WAYS_CFG_W-1:0];
        sacl_pkg::CFG_BLOCK_BITS: blk_bits_nxt = cfg_wdata[sacl_pkg::BLK_CFG_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        // Instruction fetches are taken and dropped here.
        if (in_tvalid && (in_tuser != sacl_pkg::REQ_IFETCH)) begin
          addr_nxt  = in_tdata;
          type_nxt  = in_tuser;
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        set_nxt    = set_calc;
        tag_nxt    = tag_calc;
        way_nxt    = '0;
        found_nxt  = 1'b0;
        added_nxt  = '0;
        best_nxt   = '0;
        victim_nxt = '0;
        state_nxt  = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        ram_we = line_v;
        if (way_hit) begin
          found_nxt = 1'b1;
          added_nxt = added_r + (is_modify ? ADD_W'(2) : ADD_W'(1));
        end
        if (cmp_age > best_r) begin
          best_nxt   = cmp_age;
          victim_nxt = way_r;
        end
        if (CNT_W'(way_r) + CNT_W'(1) == ways_eff) begin
          state_nxt = ST_UPD;
        end else begin
          way_nxt   = WAY_W'(way_r + 1'b1);
          state_nxt = ST_RD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          if (!found_r) begin
            ram_we    = 1'b1;
            ram_wdata = {AGE_BITS'(1), tag_r};
            valid_nxt[set_r][upd_way] = 1'b1;
            if (miss_total_r != '1) begin
              miss_total_nxt = miss_total_r + TOT_W'(1);
            end
            if (!set_has_room && (evict_total_r != '1)) begin
              evict_total_nxt = evict_total_r + TOT_W'(1);
            end
          end
          hit_total_nxt = hit_sum[TOT_W] ? '1 : hit_sum[TOT_W-1:0];
          out_valid_nxt = 1'b1;
          out_hits_nxt  = added_fin[sacl_pkg::HITS_W-1:0];
          out_miss_nxt  = !found_r;
          out_evict_nxt = !found_r && !set_has_room;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= sacl_pkg::SET_BITS_RST;
      ways_cfg_r    <= sacl_pkg::WAYS_RST;
      blk_bits_r    <= sacl_pkg::BLK_BITS_RST;
      state_r       <= ST_IDLE;
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
      out_valid_r   <= 1'b0;
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_r[s] <= '0;
      end
    end else begin
      set_bits_r    <= set_bits_nxt;
      ways_cfg_r    <= ways_cfg_nxt;
      blk_bits_r    <= blk_bits_nxt;
      state_r       <= state_nxt;
      hit_total_r   <= hit_total_nxt;
      miss_total_r  <= miss_total_nxt;
      evict_total_r <= evict_total_nxt;
      out_valid_r   <= out_valid_nxt;
      valid_r       <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r      <= type_nxt;
    addr_r      <= addr_nxt;
    tag_r       <= tag_nxt;
    set_r       <= set_nxt;
    way_r       <= way_nxt;
    found_r     <= found_nxt;
    added_r     <= added_nxt;
    best_r      <= best_nxt;
    victim_r    <= victim_nxt;
    out_hits_r  <= out_hits_nxt;
    out_miss_r  <= out_miss_nxt;
    out_evict_r <= out_evict_nxt;
  end

  // The totals only change when a new result is loaded, so they are the
  // result register's count fields.
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{sacl_pkg::OUT_PAD_W{1'b0}}, evict_total_r, miss_total_r,
                       hit_total_r, out_evict_r, out_miss_r, out_hits_r};

  a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evict_r |-> out_miss_r)
    else $error("eviction reported without a miss");

  a_miss_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_miss_r |-> (out_hits_r <= sacl_pkg::HITS_W'(1)))
    else $error("miss reported with more than one hit");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> ((set_valid & (set_valid + MAX_WAYS'(1))) == '0))
    else $error("valid bits of a set are not filled from way 0");

  a_ifetch_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == sacl_pkg::REQ_IFETCH) |=> (state_r == ST_IDLE))
    else $error("instruction fetch started a lookup");

  a_way_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (CNT_W'(way_r) < ways_eff))
    else $error("way counter ran past the ways in use");

endmodule

/* hw/rtl/sacl_ram.sv */
// Generic single-clock RAM: one write port and one read port with
// registered read data. No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* bench/tb.sv */
// Self-checking bench for set_assoc_lru_cache_sim_unit: a short directed table,
// then random accesses from small tag and set pools, under random sender bursts
// and receiver stalls. Depends on sacl_pkg and the cache unit RTL.
module tb;

  localparam int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF;
  localparam int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF;
  localparam int AGE_W        = sacl_pkg::AGE_BITS_DEF;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int NUM_LINES    = NUM_SETS * MAX_WAYS;
  localparam int ADDR_W       = sacl_pkg::ADDR_W;
  localparam int TOT_W        = sacl_pkg::TOT_W;
  localparam int HITS_W       = sacl_pkg::HITS_W;
  localparam int OUT_PAD_W    = sacl_pkg::OUT_PAD_W;
  localparam int OUT_DATA_W   = sacl_pkg::OUT_DATA_W;
  localparam int CFG_DATA_W   = sacl_pkg::CFG_DATA_W;
  localparam int SET_CFG_W    = sacl_pkg::SET_CFG_W;
  localparam int WAYS_CFG_W   = sacl_pkg::WAYS_CFG_W;
  localparam int BLK_CFG_W    = sacl_pkg::BLK_CFG_W;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 78;

  // Register index past the end of the list; writes to it must be ignored.
  localparam sacl_pkg::cfg_idx_t CFG_NO_REG = 2'd3;

  localparam int READY_ALWAYS   = 0;
  localparam int READY_ONE_IN_3 = 1;
  localparam int READY_COIN     = 2;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [TOT_W-1:0]     evictions;
    logic [TOT_W-1:0]     misses;
    logic [TOT_W-1:0]     hits;
    logic                 evicted;
    logic                 missed;
    logic [HITS_W-1:0]    hits_added;
  } access_outcome_t;

  typedef struct packed {
    bit                    is_write;
    sacl_pkg::cfg_idx_t    reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    sacl_pkg::req_type_t   kind;
    logic [ADDR_W-1:0]     addr;
    bit                    known;
    access_outcome_t       want;
  } plan_step_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata   = '0;  // address
  sacl_pkg::req_type_t   in_tuser   = sacl_pkg::REQ_IFETCH;  // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // hits_added, was_miss, was_eviction, total_hits, total_misses,
  // total_evictions, zero padding
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  sacl_pkg::cfg_idx_t    cfg_addr   = sacl_pkg::CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  set_assoc_lru_cache_sim_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mirror of the cache contents and settings.
  logic [SET_CFG_W-1:0]  set_bits_reg   = sacl_pkg::SET_BITS_RST;
  logic [WAYS_CFG_W-1:0] ways_reg       = sacl_pkg::WAYS_RST;
  logic [BLK_CFG_W-1:0]  block_bits_reg = sacl_pkg::BLK_BITS_RST;
  bit                    valid_mem [NUM_LINES];
  logic [ADDR_W-1:0]     tag_mem   [NUM_LINES];
  logic [AGE_W-1:0]      age_mem   [NUM_LINES];
  int unsigned           fill_cnt  [NUM_SETS];
  logic [TOT_W-1:0]      hit_cnt   = '0;
  logic [TOT_W-1:0]      miss_cnt  = '0;
  logic [TOT_W-1:0]      evict_cnt = '0;

  access_outcome_t pending_outcomes[$];
  int              fail_count   = 0;
  int unsigned     burst_left   = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     stall_mode   = READY_ALWAYS;
  int unsigned     stall_left   = 0;
  int unsigned     stall_phase  = 0;
  logic [ADDR_W-1:0] tag_pool [6];
  int unsigned       set_pool [2];
  plan_step_t        directed_plan[$];

  function automatic logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] v, int unsigned n);
    logic [TOT_W:0] s;
    s = {1'b0, v} + 33'(n);
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

  function automatic int unsigned eff_set_bits();
    return (32'(set_bits_reg) > MAX_SET_BITS) ? MAX_SET_BITS : 32'(set_bits_reg);
  endfunction

  function automatic void simulate_access(input sacl_pkg::req_type_t kind,
                                          input logic [ADDR_W-1:0] addr,
                                          output access_outcome_t res);
    int unsigned sbits, ways, b, set_idx, base, w, k, fill, victim, best, added;
    logic [ADDR_W-1:0] tag;
    bit found, evicted;
    res = '0;
    if (kind == sacl_pkg::REQ_IFETCH) return;
    sbits = eff_set_bits();
    ways = (ways_reg == 3'd0) ? 1 : 32'(ways_reg);
    if (ways > MAX_WAYS) ways = MAX_WAYS;
    b = 32'(block_bits_reg);
    set_idx = 32'((addr >> b) & ((64'd1 << sbits) - 64'd1));
    tag = (b + sbits < 64) ? (addr >> (b + sbits)) : '0;
    base = set_idx * MAX_WAYS;
    found = 1'b0;
    evicted = 1'b0;
    added = 0;
    for (w = 0; w < ways; w++) begin
      k = base + w;
      if (valid_mem[k]) begin
        if (tag_mem[k] == tag) begin
          found = 1'b1;
          age_mem[k] = AGE_W'(1);
          added += (kind == sacl_pkg::REQ_MODIFY) ? 2 : 1;
        end else if (age_mem[k] != '1) begin
          age_mem[k] = age_mem[k] + AGE_W'(1);
        end
      end
    end
    if (!found) begin
      miss_cnt = sat_add(miss_cnt, 1);
      fill = fill_cnt[set_idx];
      if (fill < ways) begin
        k = base + fill;
        fill_cnt[set_idx] = fill + 1;
      end else begin
        // Oldest way goes; strict compare keeps the lowest way on a tie.
        victim = 0;
        best = 0;
        for (w = 0; w < ways; w++) begin
          if (32'(age_mem[base + w]) > best) begin
            best = 32'(age_mem[base + w]);
            victim = w;
          end
        end
        evicted = 1'b1;
        evict_cnt = sat_add(evict_cnt, 1);
        k = base + victim;
      end
      tag_mem[k] = tag;
      age_mem[k] = AGE_W'(1);
      valid_mem[k] = 1'b1;
      if (kind == sacl_pkg::REQ_MODIFY) added += 1;
    end
    hit_cnt = sat_add(hit_cnt, added);
    res.hits_added = 2'(added);
    res.missed     = !found;
    res.evicted    = evicted;
    res.hits       = hit_cnt;
    res.misses     = miss_cnt;
    res.evictions  = evict_cnt;
  endfunction

  function automatic plan_step_t reg_step(sacl_pkg::cfg_idx_t idx,
                                          logic [CFG_DATA_W-1:0] val);
    plan_step_t s;
    s = '0;
    s.is_write = 1'b1;
    s.reg_idx  = idx;
    s.reg_val  = val;
    return s;
  endfunction

  function automatic plan_step_t access_step(sacl_pkg::req_type_t kind,
                                             logic [ADDR_W-1:0] addr);
    plan_step_t s;
    s = '0;
    s.kind = kind;
    s.addr = addr;
    return s;
  endfunction

  function automatic plan_step_t known_step(sacl_pkg::req_type_t kind,
                                            logic [ADDR_W-1:0] addr,
                                            logic [HITS_W-1:0] ha, logic miss, logic ev,
                                            logic [TOT_W-1:0] th, logic [TOT_W-1:0] tm,
                                            logic [TOT_W-1:0] te);
    plan_step_t s;
    s = access_step(kind, addr);
    s.known = 1'b1;
    s.want.hits_added = ha;
    s.want.missed     = miss;
    s.want.evicted    = ev;
    s.want.hits       = th;
    s.want.misses     = tm;
    s.want.evictions  = te;
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Registers change only with the unit idle: drain, then let it settle.
  task automatic write_reg(sacl_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      sacl_pkg::CFG_SET_BITS:   set_bits_reg   = val[SET_CFG_W-1:0];
      sacl_pkg::CFG_WAYS:       ways_reg       = val[WAYS_CFG_W-1:0];
      sacl_pkg::CFG_BLOCK_BITS: block_bits_reg = val[BLK_CFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_access(input sacl_pkg::req_type_t kind,
                             input logic [ADDR_W-1:0] addr,
                             input bit use_known, input access_outcome_t known);
    access_outcome_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= addr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    simulate_access(kind, addr, predicted);
    if (kind != sacl_pkg::REQ_IFETCH) begin
      pending_outcomes.push_back(use_known ? known : predicted);
    end
  endtask

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    access_outcome_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        $display("%0t: result with none pending, expected none actual %0h", $time, got);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("hits_added", 64'(want.hits_added), 64'(got.hits_added));
        check_field("was_miss", 64'(want.missed), 64'(got.missed));
        check_field("was_eviction", 64'(want.evicted), 64'(got.evicted));
        check_field("total_hits", 64'(want.hits), 64'(got.hits));
        check_field("total_misses", 64'(want.misses), 64'(got.misses));
        check_field("total_evictions", 64'(want.evictions), 64'(got.evictions));
        check_field("padding", 64'(want.pad), 64'(got.pad));
      end
    end
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(READY_ALWAYS, READY_COIN);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 1;
    unique case (stall_mode)
      READY_ALWAYS:   out_tready <= 1'b1;
      READY_ONE_IN_3: out_tready <= (stall_phase % 3 == 0);
      default:        out_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase, done_items, sbits, bbits, i;
    logic [2:0] hi;
    sacl_pkg::req_type_t kind;
    logic [ADDR_W-1:0] addr, tag_part, set_part;

    foreach (valid_mem[j]) begin
      valid_mem[j] = 1'b0;
      tag_mem[j]   = '0;
      age_mem[j]   = '0;
    end
    foreach (fill_cnt[j]) fill_cnt[j] = 0;

    // Reset state first: one way per set, 16 sets, 16-byte blocks.
    directed_plan = '{
      known_step(sacl_pkg::REQ_LOAD, 64'h0, 2'd0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd0),
      access_step(sacl_pkg::REQ_IFETCH, 64'h0),
      known_step(sacl_pkg::REQ_STORE, 64'h0, 2'd1, 1'b0, 1'b0, 32'd1, 32'd1, 32'd0),
      known_step(sacl_pkg::REQ_MODIFY, 64'h0, 2'd2, 1'b0, 1'b0, 32'd3, 32'd1, 32'd0),
      known_step(sacl_pkg::REQ_MODIFY, 64'h100, 2'd1, 1'b1, 1'b1, 32'd4, 32'd2, 32'd1),
      known_step(sacl_pkg::REQ_LOAD, '1, 2'd0, 1'b1, 1'b0, 32'd4, 32'd3, 32'd1),
      access_step(sacl_pkg::REQ_IFETCH, '1),
      reg_step(sacl_pkg::CFG_WAYS, 6'd4),
      access_step(sacl_pkg::REQ_LOAD, 64'h000),
      access_step(sacl_pkg::REQ_STORE, 64'h100),
      access_step(sacl_pkg::REQ_MODIFY, 64'h200),
      access_step(sacl_pkg::REQ_LOAD, 64'h300),
      access_step(sacl_pkg::REQ_STORE, 64'h400),
      reg_step(sacl_pkg::CFG_WAYS, 6'd0),
      reg_step(sacl_pkg::CFG_SET_BITS, 6'd7),
      reg_step(sacl_pkg::CFG_BLOCK_BITS, 6'd0),
      access_step(sacl_pkg::REQ_STORE, 64'h8000_0000_0000_0000),
      access_step(sacl_pkg::REQ_LOAD, 64'h3F),
      reg_step(sacl_pkg::CFG_BLOCK_BITS, 6'd63),
      reg_step(sacl_pkg::CFG_SET_BITS, 6'd6),
      access_step(sacl_pkg::REQ_LOAD, 64'h8000_0000_0000_0000),
      access_step(sacl_pkg::REQ_MODIFY, 64'h0),
      reg_step(sacl_pkg::CFG_SET_BITS, 6'd0),
      reg_step(sacl_pkg::CFG_BLOCK_BITS, 6'd32),
      reg_step(sacl_pkg::CFG_WAYS, 6'd5),
      access_step(sacl_pkg::REQ_MODIFY, 64'h1_0000_0000),
      access_step(sacl_pkg::REQ_MODIFY, 64'h2_0000_0000),
      access_step(sacl_pkg::REQ_STORE, 64'hFFFF_FFFF_0000_0000),
      reg_step(CFG_NO_REG, 6'h3F),
      access_step(sacl_pkg::REQ_LOAD, 64'h1_0000_0000),
      reg_step(sacl_pkg::CFG_WAYS, 6'h3F),
      reg_step(sacl_pkg::CFG_BLOCK_BITS, 6'd1),
      reg_step(sacl_pkg::CFG_SET_BITS, 6'h39),
      access_step(sacl_pkg::REQ_STORE, 64'h2),
      access_step(sacl_pkg::REQ_LOAD, 64'h6),
      access_step(sacl_pkg::REQ_MODIFY, 64'hA),
      // Fewer ways while the set holds more lines than that.
      reg_step(sacl_pkg::CFG_WAYS, 6'd2),
      access_step(sacl_pkg::REQ_LOAD, 64'h2),
      access_step(sacl_pkg::REQ_STORE, 64'hE)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[j]) begin
      if (directed_plan[j].is_write) begin
        write_reg(directed_plan[j].reg_idx, directed_plan[j].reg_val);
      end else begin
        send_access(directed_plan[j].kind, directed_plan[j].addr,
                    directed_plan[j].known, directed_plan[j].want);
      end
    end

    // Random phases: each picks new settings and a small working set so that
    // hits, fills and evictions all happen; one access in ten is a wild address.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      hi = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
      write_reg(sacl_pkg::CFG_SET_BITS, {hi, 3'($urandom_range(0, 7))});
      hi = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
      write_reg(sacl_pkg::CFG_WAYS, {hi, 3'($urandom_range(0, 7))});
      if (phase == 0 || $urandom_range(0, 1) != 0) begin
        write_reg(sacl_pkg::CFG_BLOCK_BITS, ($urandom_range(0, 4) == 0) ?
                  6'($urandom_range(56, 63)) : 6'($urandom_range(0, 10)));
      end
      if ($urandom_range(0, 5) == 0) write_reg(CFG_NO_REG, 6'($urandom));

      for (i = 0; i < 6; i++) begin
        tag_pool[i] = (i == 5) ? {$urandom, $urandom} : 64'($urandom_range(0, 7));
      end
      set_pool[0] = $urandom_range(0, NUM_SETS - 1);
      set_pool[1] = $urandom_range(0, NUM_SETS - 1);
      sbits = eff_set_bits();
      bbits = 32'(block_bits_reg);

      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        kind = sacl_pkg::req_type_t'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          tag_part = tag_pool[$urandom_range(0, 5)];
          set_part = 64'(set_pool[$urandom_range(0, 1)]) & ((64'd1 << sbits) - 64'd1);
          addr = (bbits + sbits < 64) ? (tag_part << (bbits + sbits)) : '0;
          addr = addr | (set_part << bbits) |
                 ({$urandom, $urandom} & ((64'd1 << bbits) - 64'd1));
        end
        send_access(kind, addr, 1'b0, '0);
        done_items++;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
